>>> src/sme_pkg.sv
// Shared types, codes and decode tables of the stack machine execute unit.
`timescale 1ns / 1ps
package sme_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned MemBytesDef   = 4096;
  localparam int unsigned DataW         = 32;
  localparam int unsigned KindW         = 5;
  localparam int unsigned EventW        = 2;
  localparam int unsigned CondW         = 2;
  localparam int unsigned ErrW          = 3;
  localparam int unsigned DepthW        = 9;

  typedef enum logic [KindW-1:0] {
    K_PUSH, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_EQ, K_NEQ,
    K_GT, K_LT, K_GE, K_LE, K_NOT, K_AND, K_OR, K_XOR,
    K_SHL, K_SHR, K_PRINT, K_DUP, K_SWAP, K_DROP, K_OVER, K_ROT,
    K_NIP, K_DUPD, K_SWAPD, K_STORE, K_LOAD, K_STORECOUNT, K_TEST, K_EXIT
  } kind_e;

  typedef enum logic [EventW-1:0] {EV_NONE, EV_PRINT, EV_EXIT, EV_TEST} event_e;

  typedef enum logic [CondW-1:0] {COND_FALSE, COND_TRUE, COND_OTHER} cond_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE, ERR_UNDERFLOW, ERR_OVERFLOW, ERR_DIV_ZERO, ERR_ADDRESS
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_LOAD, ST_WRITE, ST_RESULT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

  // Number of stack entries an instruction needs on the stack.
  function automatic logic [1:0] need_of(kind_e k);
    logic [1:0] n;
    unique case (k)
      K_PUSH, K_STORECOUNT: n = 2'd0;
      K_NOT, K_PRINT, K_DUP, K_DROP, K_LOAD, K_TEST, K_EXIT: n = 2'd1;
      K_ROT, K_SWAPD: n = 2'd3;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

  // Net change of the stack depth.
  function automatic logic signed [2:0] net_of(kind_e k);
    logic signed [2:0] n;
    unique case (k)
      K_PUSH, K_DUP, K_OVER, K_DUPD, K_STORECOUNT: n = 3'sd1;
      K_NOT, K_SWAP, K_ROT, K_SWAPD, K_LOAD: n = 3'sd0;
      K_STORE: n = -3'sd2;
      default: n = -3'sd1;
    endcase
    return n;
  endfunction

endpackage

>>> src/stack_machine_execute_unit.sv
// Stack machine execute unit: one instruction item in, one result item out.
// Each item runs four stack reads, execute, three write slots and the result register;
// load adds a byte read, div and mod add the 32 divider steps, divide by zero or bad
// address skip the write slots, and stack underflow or overflow go straight to result.
// One item at a time: the next is taken once the result is registered and the unit is
// idle again. Reset clears counts; byte memory zero-fills after reset, taking no item until done.
`timescale 1ns / 1ps
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDef,
  parameter int unsigned MEM_BYTES   = sme_pkg::MemBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] immediate
  input  logic [4:0]  s_axis_tuser,   // [4:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] value, [33:32] condition,
                                      // [36:34] error, [45:37] depth, [47:46] zero
  output logic [1:0]  m_axis_tuser    // [1:0] event_res
);

  localparam int unsigned W    = sme_pkg::DataW;
  localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SPW  = $clog2(STACK_DEPTH);
  localparam int unsigned MAW  = $clog2(MEM_BYTES);

  sme_pkg::state_e state_q, state_d;
  sme_pkg::kind_e  kind_q, kind_in;
  sme_pkg::err_e   err_q, err_d;

  logic [W-1:0]    imm_q, a_q, b_q, c_q, sc_q;
  logic [CW-1:0]   cnt_q, newcnt_q, newcnt_d, t_full;
  logic [1:0]      rd_q, wi_q;
  logic [SPW-1:0]  wa_q [3];
  logic [W-1:0]    wd_q [3];
  logic [2:0]      wv_q;
  logic [SPW-1:0]  wa_d [3];
  logic [W-1:0]    wd_d [3];
  logic [2:0]      wv_d;

  logic [W-1:0]    stk_mem [STACK_DEPTH];
  logic [W-1:0]    stk_rdata_q;
  logic [SPW-1:0]  stk_raddr;
  logic            stk_we;

  logic [SPW-1:0]  idx_n, idx_t, idx_t1, idx_t2;
  logic            accept, underflow, overflow, out_free;
  logic [W-1:0]    alu_r;
  logic            b_bad, a_bad, byte_we, byte_busy;
  logic [7:0]      byte_rdata;
  logic signed [CW-1:0] net_ext;

  sme_pkg::div_req_t div_req;
  sme_pkg::div_rsp_t div_rsp;

  logic            m_valid_q;
  logic [1:0]      out_ev_q;
  logic [W-1:0]    out_val_q;
  logic [1:0]      out_cond_q;
  logic [2:0]      out_err_q;
  logic [8:0]      out_depth_q;

  assign kind_in   = sme_pkg::kind_e'(s_axis_tuser);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign underflow = cnt_q < CW'(sme_pkg::need_of(kind_in));
  assign overflow  = (sme_pkg::net_of(kind_in) > 3'sd0) && (cnt_q == CW'(STACK_DEPTH));
  assign net_ext   = CW'(sme_pkg::net_of(kind_in));
  assign newcnt_d  = cnt_q + CW'(net_ext);

  assign t_full = cnt_q - CW'(1);
  assign idx_n  = cnt_q[SPW-1:0];
  assign idx_t  = t_full[SPW-1:0];
  assign idx_t1 = idx_t - SPW'(1);
  assign idx_t2 = idx_t - SPW'(2);

  assign b_bad = b_q >= W'(MEM_BYTES);
  assign a_bad = a_q >= W'(MEM_BYTES);

  // ALU for the two-operand kinds other than div and mod, second-from-top op top
  always_comb begin
    alu_r = '0;
    unique case (kind_q)
      sme_pkg::K_ADD: alu_r = b_q + a_q;
      sme_pkg::K_SUB: alu_r = b_q - a_q;
      sme_pkg::K_MUL: alu_r = b_q * a_q;
      sme_pkg::K_EQ:  alu_r = W'(b_q == a_q);
      sme_pkg::K_NEQ: alu_r = W'(b_q != a_q);
      sme_pkg::K_GT:  alu_r = W'($signed(b_q) > $signed(a_q));
      sme_pkg::K_LT:  alu_r = W'($signed(b_q) < $signed(a_q));
      sme_pkg::K_GE:  alu_r = W'($signed(b_q) >= $signed(a_q));
      sme_pkg::K_LE:  alu_r = W'($signed(b_q) <= $signed(a_q));
      sme_pkg::K_AND: alu_r = b_q & a_q;
      sme_pkg::K_OR:  alu_r = b_q | a_q;
      sme_pkg::K_XOR: alu_r = b_q ^ a_q;
      sme_pkg::K_SHL: alu_r = b_q << a_q[4:0];
      sme_pkg::K_SHR: alu_r = W'($signed(b_q) >>> a_q[4:0]);
      default:        alu_r = '0;
    endcase
  end

  // Stack write plan for the exec step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wa_d[i] = idx_t;
      wd_d[i] = '0;
    end
    wv_d = 3'b000;
    unique case (kind_q)
      sme_pkg::K_PUSH: begin
        wa_d[0] = idx_n; wd_d[0] = imm_q; wv_d = 3'b001;
      end
      sme_pkg::K_ADD, sme_pkg::K_SUB, sme_pkg::K_MUL, sme_pkg::K_DIV, sme_pkg::K_MOD,
      sme_pkg::K_EQ, sme_pkg::K_NEQ, sme_pkg::K_GT, sme_pkg::K_LT, sme_pkg::K_GE,
      sme_pkg::K_LE, sme_pkg::K_AND, sme_pkg::K_OR, sme_pkg::K_XOR, sme_pkg::K_SHL,
      sme_pkg::K_SHR: begin
        wa_d[0] = idx_t1; wd_d[0] = alu_r; wv_d = 3'b001;
      end
      sme_pkg::K_NOT: begin
        wa_d[0] = idx_t; wd_d[0] = W'(a_q == '0); wv_d = 3'b001;
      end
      sme_pkg::K_DUP: begin
        wa_d[0] = idx_n; wd_d[0] = a_q; wv_d = 3'b001;
      end
      sme_pkg::K_SWAP: begin
        wa_d[0] = idx_t; wd_d[0] = b_q;
        wa_d[1] = idx_t1; wd_d[1] = a_q; wv_d = 3'b011;
      end
      sme_pkg::K_OVER: begin
        wa_d[0] = idx_n; wd_d[0] = b_q; wv_d = 3'b001;
      end
      sme_pkg::K_ROT: begin
        wa_d[0] = idx_t2; wd_d[0] = b_q;
        wa_d[1] = idx_t1; wd_d[1] = a_q;
        wa_d[2] = idx_t; wd_d[2] = c_q; wv_d = 3'b111;
      end
      sme_pkg::K_NIP: begin
        wa_d[0] = idx_t1; wd_d[0] = a_q; wv_d = 3'b001;
      end
      sme_pkg::K_DUPD: begin
        wa_d[0] = idx_t; wd_d[0] = b_q;
        wa_d[1] = idx_n; wd_d[1] = a_q; wv_d = 3'b011;
      end
      sme_pkg::K_SWAPD: begin
        wa_d[0] = idx_t2; wd_d[0] = b_q;
        wa_d[1] = idx_t1; wd_d[1] = c_q; wv_d = 3'b011;
      end
      sme_pkg::K_LOAD: begin
        wa_d[0] = idx_t; wv_d = 3'b001;
      end
      sme_pkg::K_STORECOUNT: begin
        wa_d[0] = idx_n; wd_d[0] = sc_q; wv_d = 3'b001;
      end
      default: wv_d = 3'b000;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    unique case (state_q)
      sme_pkg::ST_IDLE: begin
        if (accept) begin
          if (underflow) begin
            err_d = sme_pkg::ERR_UNDERFLOW; state_d = sme_pkg::ST_RESULT;
          end else if (overflow) begin
            err_d = sme_pkg::ERR_OVERFLOW; state_d = sme_pkg::ST_RESULT;
          end else begin
            err_d = sme_pkg::ERR_NONE; state_d = sme_pkg::ST_READ;
          end
        end
      end
      sme_pkg::ST_READ: begin
        if (rd_q == 2'd3) state_d = sme_pkg::ST_EXEC;
      end
      sme_pkg::ST_EXEC: begin
        priority if ((kind_q == sme_pkg::K_DIV || kind_q == sme_pkg::K_MOD) && a_q == '0) begin
          err_d = sme_pkg::ERR_DIV_ZERO; state_d = sme_pkg::ST_RESULT;
        end else if (kind_q == sme_pkg::K_DIV || kind_q == sme_pkg::K_MOD) begin
          state_d = sme_pkg::ST_DIV;
        end else if ((kind_q == sme_pkg::K_STORE && b_bad) ||
                     (kind_q == sme_pkg::K_LOAD && a_bad)) begin
          err_d = sme_pkg::ERR_ADDRESS; state_d = sme_pkg::ST_RESULT;
        end else if (kind_q == sme_pkg::K_LOAD) begin
          state_d = sme_pkg::ST_LOAD;
        end else begin
          state_d = sme_pkg::ST_WRITE;
        end
      end
      sme_pkg::ST_DIV: begin
        if (div_rsp.done) state_d = sme_pkg::ST_WRITE;
      end
      sme_pkg::ST_LOAD: state_d = sme_pkg::ST_WRITE;
      sme_pkg::ST_WRITE: begin
        if (wi_q == 2'd2) state_d = sme_pkg::ST_RESULT;
      end
      sme_pkg::ST_RESULT: begin
        if (out_free) state_d = sme_pkg::ST_IDLE;
      end
      default: state_d = sme_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready    = (state_q == sme_pkg::ST_IDLE) && !byte_busy;
    stk_raddr        = idx_t - SPW'(rd_q);
    stk_we           = (state_q == sme_pkg::ST_WRITE) && wv_q[wi_q];
    byte_we          = (state_q == sme_pkg::ST_EXEC) && (kind_q == sme_pkg::K_STORE) && !b_bad;
    div_req.start    = (state_q == sme_pkg::ST_EXEC) && (a_q != '0) &&
                       (kind_q == sme_pkg::K_DIV || kind_q == sme_pkg::K_MOD);
    div_req.dividend = b_q;
    div_req.divisor  = a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sme_pkg::ST_IDLE;
      err_q     <= sme_pkg::ERR_NONE;
      cnt_q     <= '0;
      sc_q      <= '0;
      rd_q      <= '0;
      wi_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      if (accept) rd_q <= '0;
      else if (state_q == sme_pkg::ST_READ) rd_q <= rd_q + 2'd1;
      if (state_q == sme_pkg::ST_EXEC) wi_q <= '0;
      else if (state_q == sme_pkg::ST_WRITE) wi_q <= wi_q + 2'd1;
      if (byte_we) sc_q <= sc_q + W'(1);
      if (m_axis_tready) m_valid_q <= 1'b0;
      if (state_q == sme_pkg::ST_RESULT && out_free) begin
        m_valid_q <= 1'b1;
        if (err_q == sme_pkg::ERR_NONE) cnt_q <= newcnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_in;
      imm_q    <= s_axis_tdata;
      newcnt_q <= newcnt_d;
    end
    if (state_q == sme_pkg::ST_READ) begin
      unique case (rd_q)
        2'd1:    a_q <= stk_rdata_q;
        2'd2:    b_q <= stk_rdata_q;
        2'd3:    c_q <= stk_rdata_q;
        default: ;
      endcase
    end
    if (state_q == sme_pkg::ST_EXEC) begin
      wa_q <= wa_d;
      wd_q <= wd_d;
      wv_q <= wv_d;
    end
    if (state_q == sme_pkg::ST_DIV && div_rsp.done) begin
      wd_q[0] <= (kind_q == sme_pkg::K_DIV) ? div_rsp.quotient : div_rsp.remainder;
    end
    if (state_q == sme_pkg::ST_LOAD) begin
      wd_q[0] <= {{(W-8){byte_rdata[7]}}, byte_rdata};
    end
    if (state_q == sme_pkg::ST_RESULT && out_free) begin
      out_ev_q   <= sme_pkg::EV_NONE;
      out_val_q  <= '0;
      out_cond_q <= sme_pkg::COND_FALSE;
      out_err_q  <= err_q;
      out_depth_q <= (err_q == sme_pkg::ERR_NONE) ? sme_pkg::DepthW'(newcnt_q)
                                                  : sme_pkg::DepthW'(cnt_q);
      if (err_q == sme_pkg::ERR_NONE) begin
        unique case (kind_q)
          sme_pkg::K_PRINT: begin
            out_ev_q <= sme_pkg::EV_PRINT; out_val_q <= a_q;
          end
          sme_pkg::K_EXIT: begin
            out_ev_q <= sme_pkg::EV_EXIT; out_val_q <= a_q;
          end
          sme_pkg::K_TEST: begin
            out_ev_q <= sme_pkg::EV_TEST;
            priority if (a_q == '0) out_cond_q <= sme_pkg::COND_FALSE;
            else if (a_q == W'(1)) out_cond_q <= sme_pkg::COND_TRUE;
            else out_cond_q <= sme_pkg::COND_OTHER;
          end
          default: ;
        endcase
      end
    end
  end

  // Data stack memory: one read and one write port
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[wa_q[wi_q]] <= wd_q[wi_q];
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  sme_byte_ram #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (MAW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (byte_we),
    .waddr_i (b_q[MAW-1:0]),
    .wdata_i (a_q[7:0]),
    .raddr_i (a_q[MAW-1:0]),
    .rdata_o (byte_rdata),
    .busy_o  (byte_busy)
  );

  sme_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tdata  = {2'b00, out_depth_q, out_err_q, out_cond_q, out_val_q};

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == sme_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != sme_pkg::ST_IDLE)
    else $error("item accepted but unit stayed idle");

  a_err_keeps_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sme_pkg::ST_RESULT && err_q != sme_pkg::ERR_NONE && out_free)
      |=> cnt_q == $past(cnt_q))
    else $error("stack count changed on error");
`endif

endmodule

>>> src/sme_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sme_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sme_pkg::div_req_t  req_i,
  output sme_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned W = sme_pkg::DataW;

  logic             busy_q, done_q, qneg_q, rneg_q;
  logic [4:0]       cnt_q;
  logic [W-1:0]     rem_q, quo_q, dvs_q;
  logic [W:0]       shifted, diff;
  logic [W-1:0]     dvd_mag, dvs_mag;

  assign dvd_mag = req_i.dividend[W-1] ? (~req_i.dividend + W'(1)) : req_i.dividend;
  assign dvs_mag = req_i.divisor[W-1] ? (~req_i.divisor + W'(1)) : req_i.divisor;
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= dvd_mag;
      dvs_q  <= dvs_mag;
      qneg_q <= req_i.dividend[W-1] ^ req_i.divisor[W-1];
      rneg_q <= req_i.dividend[W-1];
    end else if (busy_q) begin
      // restoring step: keep the trial difference when it does not go negative
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = qneg_q ? (~quo_q + W'(1)) : quo_q;
  assign rsp_o.remainder = rneg_q ? (~rem_q + W'(1)) : rem_q;

endmodule

>>> src/sme_byte_ram.sv
// Byte memory with registered read and a zero-fill sweep after reset.
`timescale 1ns / 1ps
module sme_byte_ram #(
  parameter int unsigned MEM_BYTES = sme_pkg::MemBytesDef,
  parameter int unsigned AW        = $clog2(MEM_BYTES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o,
  output logic          busy_o
);

  logic [7:0]    mem [MEM_BYTES];
  logic          busy_q;
  logic [AW-1:0] clr_q;
  logic [7:0]    rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(MEM_BYTES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule
